[src/frto_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the fragment RTO estimator.
// No dependencies; used by every module of the block except frto_fifo.
package frto_pkg;

	localparam int MAX_FRAGMENTS = 32;

	// func codes on the input channel
	localparam logic [2:0] FUNC_OPEN  = 3'd0;
	localparam logic [2:0] FUNC_START = 3'd1;
	localparam logic [2:0] FUNC_ACK   = 3'd2;
	localparam logic [2:0] FUNC_TICK  = 3'd3;
	localparam logic [2:0] FUNC_LIFE  = 3'd4;
	localparam logic [2:0] FUNC_FREE  = 3'd5;

	// configuration register indexes
	localparam logic [2:0] CFG_RTO_FLOOR   = 3'd0;
	localparam logic [2:0] CFG_RTO_INITIAL = 3'd1;
	localparam logic [2:0] CFG_VAR_GAIN    = 3'd2;
	localparam logic [2:0] CFG_ALPHA       = 3'd3;
	localparam logic [2:0] CFG_BETA        = 3'd4;
	localparam logic [2:0] CFG_TICK_SHIFT  = 3'd5;
	localparam logic [2:0] CFG_HOLD_TICKS  = 3'd6;

	// configuration reset values
	localparam logic [15:0] RTO_FLOOR_RST   = 16'd100;
	localparam logic [15:0] RTO_INITIAL_RST = 16'd3000;
	localparam logic [2:0]  VAR_GAIN_RST    = 3'd2;
	localparam logic [2:0]  ALPHA_RST       = 3'd3;
	localparam logic [2:0]  BETA_RST        = 3'd2;
	localparam logic [3:0]  TICK_SHIFT_RST  = 4'd0;
	localparam logic [7:0]  HOLD_TICKS_RST  = 8'd10;

	localparam logic [31:0] FIRST_FRAG_BIT = 32'h8000_0000;
	localparam logic [31:0] TAIL_MASK      = 32'h7FFF_FFFF;

	typedef enum logic [2:0] {
		OP_OPEN,
		OP_START,
		OP_ACK,
		OP_TICK,
		OP_LIFE,
		OP_FREE,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] now_ms;
		logic [31:0] ack_bits;
		logic [4:0]  last_index;
		logic        queue_accepts;
		logic        free_success;
	} in_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t         op;
		logic [31:0] now_ms;
		logic [31:0] ack_bits;
		logic [4:0]  last_frag;
		logic        queue_accepts;
		logic        free_success;
	} cmd_t;

	typedef struct packed {
		logic        request_valid;
		logic [31:0] request_bits;
		logic [31:0] resend_bits;
		logic        all_acked;
		logic [15:0] timeout_ticks;
		logic [31:0] smoothed_rtt;
		logic [31:0] rtt_variance;
		logic        done_valid;
		logic        done_ok;
		logic        busy_res;
	} res_t;

	typedef struct packed {
		logic [15:0] rto_floor;
		logic [15:0] rto_initial;
		logic [2:0]  var_gain_shift;
		logic [2:0]  alpha_shift;
		logic [2:0]  beta_shift;
		logic [3:0]  tick_shift;
		logic [7:0]  hold_ticks;
	} cfg_t;

endpackage

[src/frto_fifo.sv]
`timescale 1ns / 1ps
// Two-entry queue with count-based full/empty, payload of any packed type.
// No dependencies.
module frto_fifo #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);

	T           mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q;
	logic       rd_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

endmodule

[src/frto_front.sv]
`timescale 1ns / 1ps
// Front end: accepts input transactions, decodes func and clamps the
// fragment index, then queues the command. Uses frto_pkg and frto_fifo.
module frto_front #(
	parameter int MAX_FRAGMENTS = frto_pkg::MAX_FRAGMENTS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  frto_pkg::in_t   item,
	output logic            full,
	input  logic            cmd_take,
	output frto_pkg::cmd_t  cmd,
	output logic            cmd_valid
);

	frto_pkg::cmd_t cmd_in;
	logic           cmd_empty;

	always_comb begin
		cmd_in               = '0;
		cmd_in.now_ms        = item.now_ms;
		cmd_in.ack_bits      = item.ack_bits;
		cmd_in.queue_accepts = item.queue_accepts;
		cmd_in.free_success  = item.free_success;
		if ({1'b0, item.last_index} > 6'(MAX_FRAGMENTS - 1))
			cmd_in.last_frag = 5'(MAX_FRAGMENTS - 1);
		else
			cmd_in.last_frag = item.last_index;
		case (item.func)
			frto_pkg::FUNC_OPEN:  cmd_in.op = frto_pkg::OP_OPEN;
			frto_pkg::FUNC_START: cmd_in.op = frto_pkg::OP_START;
			frto_pkg::FUNC_ACK:   cmd_in.op = frto_pkg::OP_ACK;
			frto_pkg::FUNC_TICK:  cmd_in.op = frto_pkg::OP_TICK;
			frto_pkg::FUNC_LIFE:  cmd_in.op = frto_pkg::OP_LIFE;
			frto_pkg::FUNC_FREE:  cmd_in.op = frto_pkg::OP_FREE;
			default:              cmd_in.op = frto_pkg::OP_NONE;
		endcase
	end

	frto_fifo #(.T(frto_pkg::cmd_t)) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_take),
		.dout  (cmd),
		.empty (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;

endmodule

[src/frto_back.sv]
`timescale 1ns / 1ps
// Back end: configuration registers, estimator state and the per-command
// update. One command per cycle while the result queue has room. Uses frto_pkg.
module frto_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_idx,
	input  logic [15:0]     cfg_wdata,
	input  logic            cmd_valid,
	input  frto_pkg::cmd_t  cmd,
	input  logic            res_room,
	output logic            cmd_take,
	output frto_pkg::res_t  res
);

	frto_pkg::cfg_t cfg_q;

	logic [31:0] srtt_q, rttvar_q, stamp_q;
	logic [15:0] countdown_q;
	logic        timer_on_q, timed_out_q;
	logic [4:0]  last_q;
	logic [7:0]  life_q;

	logic [31:0] srtt_d, rttvar_d, stamp_d;
	logic [15:0] countdown_d;
	logic        timer_on_d, timed_out_d;
	logic [4:0]  last_d;
	logic [7:0]  life_d;

	logic        busy;
	logic [38:0] var_term;
	logic [38:0] var_floored;
	logic [39:0] tmo_sum;
	logic [39:0] tmo_shift;
	logic [15:0] tmo_ticks;
	logic [31:0] sample;
	logic [31:0] diff;
	logic [32:0] var_new;
	logic [32:0] srtt_new;
	logic [31:0] var_sat, srtt_sat;

	assign cmd_take = cmd_valid && res_room;
	assign busy     = (life_q != 8'd0);

	// timeout from current estimate; the sum is already at or above the floor
	always_comb begin
		var_term    = {7'd0, rttvar_q} << cfg_q.var_gain_shift;
		var_floored = (var_term < {23'd0, cfg_q.rto_floor}) ? {23'd0, cfg_q.rto_floor} : var_term;
		tmo_sum     = {1'b0, var_floored} + {8'd0, srtt_q};
		tmo_shift   = tmo_sum >> cfg_q.tick_shift;
		tmo_ticks   = (|tmo_shift[39:16]) ? 16'hFFFF : tmo_shift[15:0];
	end

	always_comb begin
		sample   = cmd.now_ms - stamp_q;
		diff     = (sample > srtt_q) ? (sample - srtt_q) : (srtt_q - sample);
		var_new  = {1'b0, rttvar_q - (rttvar_q >> cfg_q.beta_shift)}
		         + {1'b0, diff >> cfg_q.beta_shift};
		srtt_new = {1'b0, srtt_q - (srtt_q >> cfg_q.alpha_shift)}
		         + {1'b0, sample >> cfg_q.alpha_shift};
		var_sat  = var_new[32] ? 32'hFFFF_FFFF : var_new[31:0];
		srtt_sat = srtt_new[32] ? 32'hFFFF_FFFF : srtt_new[31:0];
	end

	always_comb begin
		srtt_d      = srtt_q;
		rttvar_d    = rttvar_q;
		stamp_d     = stamp_q;
		countdown_d = countdown_q;
		timer_on_d  = timer_on_q;
		timed_out_d = timed_out_q;
		last_d      = last_q;
		life_d      = life_q;
		res         = '0;
		case (cmd.op)
			frto_pkg::OP_OPEN: begin
				srtt_d      = {16'd0, cfg_q.rto_initial};
				rttvar_d    = {17'd0, cfg_q.rto_initial[15:1]};
				stamp_d     = 32'd0;
				countdown_d = cfg_q.rto_initial >> cfg_q.tick_shift;
				timed_out_d = 1'b0;
				timer_on_d  = 1'b0;
				last_d      = cmd.last_frag;
				life_d      = (cfg_q.hold_ticks == 8'd0) ? 8'd1 : cfg_q.hold_ticks;
			end
			frto_pkg::OP_START: begin
				if (busy) begin
					countdown_d = tmo_ticks;
					stamp_d     = cmd.now_ms;
					timer_on_d  = 1'b1;
				end
			end
			frto_pkg::OP_ACK: begin
				if (busy) begin
					// Karn: no sample once the timer has expired
					if (timer_on_q) begin
						if (!timed_out_q) begin
							srtt_d   = srtt_sat;
							rttvar_d = var_sat;
						end
						timer_on_d = 1'b0;
					end
					res.resend_bits = ~cmd.ack_bits & ~(frto_pkg::TAIL_MASK >> last_q);
					res.all_acked   = (res.resend_bits == 32'd0);
				end
			end
			frto_pkg::OP_TICK: begin
				if (busy && timer_on_q) begin
					if (countdown_q <= 16'd1) begin
						timed_out_d       = 1'b1;
						timer_on_d        = 1'b0;
						res.request_valid = 1'b1;
						res.request_bits  = frto_pkg::FIRST_FRAG_BIT >> last_q;
						// request refused: rearm right away
						if (!cmd.queue_accepts) begin
							countdown_d = tmo_ticks;
							stamp_d     = cmd.now_ms;
							timer_on_d  = 1'b1;
						end
					end else begin
						countdown_d = countdown_q - 16'd1;
					end
				end
			end
			frto_pkg::OP_LIFE: begin
				if (busy) begin
					life_d = life_q - 8'd1;
					if (life_q == 8'd1) begin
						timer_on_d     = 1'b0;
						res.done_valid = 1'b1;
					end
				end
			end
			frto_pkg::OP_FREE: begin
				if (busy) begin
					life_d         = 8'd0;
					timer_on_d     = 1'b0;
					res.done_valid = 1'b1;
					res.done_ok    = cmd.free_success;
				end
			end
			default: begin
			end
		endcase
		res.timeout_ticks = countdown_d;
		res.smoothed_rtt  = srtt_d;
		res.rtt_variance  = rttvar_d;
		res.busy_res      = (life_d != 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rto_floor      <= frto_pkg::RTO_FLOOR_RST;
			cfg_q.rto_initial    <= frto_pkg::RTO_INITIAL_RST;
			cfg_q.var_gain_shift <= frto_pkg::VAR_GAIN_RST;
			cfg_q.alpha_shift    <= frto_pkg::ALPHA_RST;
			cfg_q.beta_shift     <= frto_pkg::BETA_RST;
			cfg_q.tick_shift     <= frto_pkg::TICK_SHIFT_RST;
			cfg_q.hold_ticks     <= frto_pkg::HOLD_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				frto_pkg::CFG_RTO_FLOOR:   cfg_q.rto_floor      <= cfg_wdata;
				frto_pkg::CFG_RTO_INITIAL: cfg_q.rto_initial    <= cfg_wdata;
				frto_pkg::CFG_VAR_GAIN:    cfg_q.var_gain_shift <= cfg_wdata[2:0];
				frto_pkg::CFG_ALPHA:       cfg_q.alpha_shift    <= cfg_wdata[2:0];
				frto_pkg::CFG_BETA:        cfg_q.beta_shift     <= cfg_wdata[2:0];
				frto_pkg::CFG_TICK_SHIFT:  cfg_q.tick_shift     <= cfg_wdata[3:0];
				frto_pkg::CFG_HOLD_TICKS:  cfg_q.hold_ticks     <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srtt_q      <= {16'd0, frto_pkg::RTO_INITIAL_RST};
			rttvar_q    <= {17'd0, frto_pkg::RTO_INITIAL_RST[15:1]};
			stamp_q     <= 32'd0;
			countdown_q <= frto_pkg::RTO_INITIAL_RST >> frto_pkg::TICK_SHIFT_RST;
			timer_on_q  <= 1'b0;
			timed_out_q <= 1'b0;
			last_q      <= 5'd0;
			life_q      <= 8'd0;
		end else if (cmd_take) begin
			srtt_q      <= srtt_d;
			rttvar_q    <= rttvar_d;
			stamp_q     <= stamp_d;
			countdown_q <= countdown_d;
			timer_on_q  <= timer_on_d;
			timed_out_q <= timed_out_d;
			last_q      <= last_d;
			life_q      <= life_d;
		end
	end

endmodule

[src/fragment_rto_estimator.sv]
`timescale 1ns / 1ps
// Retransmission-timeout controller for one fragmented datagram.
// Uses frto_pkg, frto_front, frto_back and frto_fifo.
//
// Usage:
//   Input channel: drive item and push; a transaction is taken at a rising
//   edge with push high and full low. Result channel: while empty is low the
//   oldest result sits on result; pop with empty low takes it. Every input
//   transaction yields exactly one result, in order.
//   Configuration: cfg_we with cfg_idx/cfg_wdata writes one register at the
//   edge; write only while no transaction is in flight.
//   A result is held in the command queue and then in the result queue
//   before it is visible on result.
//   Throughput: one transaction per cycle while the result queue has room,
//   set by the state update in the back end; the two-entry command queue and
//   two-entry result queue absorb stalls on either side.
//   Reset: arst_n low clears both queues, loads the register defaults and
//   puts the estimator in its initial state with no datagram open.
//   A stalled receiver fills the result queue, then the command queue, and
//   full rises; nothing is dropped.
module fragment_rto_estimator #(
	parameter int MAX_FRAGMENTS = frto_pkg::MAX_FRAGMENTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  frto_pkg::in_t  item,
	output logic           full,
	input  logic           pop,
	output frto_pkg::res_t result,
	output logic           empty,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [15:0]    cfg_wdata
);

	frto_pkg::cmd_t cmd;
	frto_pkg::res_t res;
	logic           cmd_valid;
	logic           cmd_take;
	logic           res_full;

	frto_front #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_take (cmd_take),
		.cmd      (cmd),
		.cmd_valid(cmd_valid)
	);

	frto_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.res_room (!res_full),
		.cmd_take (cmd_take),
		.res      (res)
	);

	frto_fifo #(.T(frto_pkg::res_t)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_take),
		.din   (res),
		.full  (res_full),
		.pop   (pop),
		.dout  (result),
		.empty (empty)
	);

endmodule

[src/frto_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for fragment_rto_estimator, attached with bind.
// Uses frto_pkg.
module frto_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pop,
	input frto_pkg::res_t result,
	input logic           empty
);

	a_req_bits: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.request_valid |-> result.request_bits == 32'd0)
		else $error("request bits without a request");

	a_all_acked: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.all_acked |-> result.resend_bits == 32'd0)
		else $error("all_acked with fragments still missing");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.done_valid |-> !result.busy_res)
		else $error("datagram still open after release");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

endmodule

bind fragment_rto_estimator frto_checker u_frto_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.pop   (pop),
	.result(result),
	.empty (empty)
);
